[design/kissdf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KISS deframer package
// Byte codes, result kinds and the result record shared by the deframer files.
// ----------------------------------------------------------------------------
package kissdf_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned LEN_W   = 9;
  localparam int unsigned PORT_W  = 8;

  // Default frame size limit (command byte included).
  localparam int unsigned MAX_FRAME_BYTES_DEF = 512;

  // KISS special bytes.
  localparam logic [BYTE_W-1:0] FEND  = 8'hC0;
  localparam logic [BYTE_W-1:0] FESC  = 8'hDB;
  localparam logic [BYTE_W-1:0] TFEND = 8'hDC;
  localparam logic [BYTE_W-1:0] TFESC = 8'hDD;

  // A command byte marks a data frame when its low nibble is zero.
  localparam logic [BYTE_W-1:0] CMD_MASK = 8'h0F;
  localparam logic [BYTE_W-1:0] CMD_DATA = 8'h00;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ABORT = 2'd2
  } kind_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  length;
    logic [PORT_W-1:0] port;
  } result_t;

endpackage

[design/kissdf_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KISS deframer channel interfaces
// Receive byte stream, result stream and port register write channel.
// ----------------------------------------------------------------------------
interface kissdf_byte_if
  import kissdf_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface kissdf_res_if
  import kissdf_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] out_kind;
  logic [BYTE_W-1:0] out_byte;
  logic [LEN_W-1:0]  out_length;
  logic [PORT_W-1:0] out_port;

  modport source (output valid, output out_kind, output out_byte,
                  output out_length, output out_port, input ready);
  modport sink   (input valid, input out_kind, input out_byte,
                  input out_length, input out_port, output ready);
endinterface

interface kissdf_cfg_if
  import kissdf_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [PORT_W-1:0] port_number;

  modport source (output valid, output port_number, input ready);
  modport sink   (input valid, input port_number, output ready);
endinterface

[design/kissdf_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KISS deframer decode step
// Holds the framing state and turns one registered byte into at most one result.
// ----------------------------------------------------------------------------
module kissdf_decode
  import kissdf_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic [PORT_W-1:0] port_number,
  output result_t           res
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic             escape_pending, escape_pending_next;
  logic             frame_open, frame_open_next;
  logic             is_data_frame, is_data_frame_next;

  logic [BYTE_W-1:0] b;
  logic              go;
  logic [CNT_W-1:0]  count_m1;

  assign count_m1 = byte_count - CNT_ONE;

  always_comb begin
    byte_count_next     = byte_count;
    escape_pending_next = escape_pending;
    frame_open_next     = frame_open;
    is_data_frame_next  = is_data_frame;
    res                 = '0;
    b                   = in_byte;
    go                  = 1'b0;

    if (step) begin
      if (in_byte == FEND) begin
        // Every delimiter opens a new frame; report an old data frame with payload.
        if (frame_open && is_data_frame && (byte_count > CNT_ONE)) begin
          res.valid  = 1'b1;
          res.kind   = KIND_DONE;
          res.length = LEN_W'(count_m1);
          res.port   = port_number;
        end
        frame_open_next     = 1'b1;
        byte_count_next     = '0;
        escape_pending_next = 1'b0;
        is_data_frame_next  = 1'b0;
      end else if (frame_open) begin
        go = 1'b1;
        if (escape_pending) begin
          if (in_byte == TFEND) begin
            b = FEND;
          end else if (in_byte == TFESC) begin
            b = FESC;
          end
          escape_pending_next = 1'b0;
        end else if (in_byte == FESC) begin
          escape_pending_next = 1'b1;
          go = 1'b0;
        end

        if (go) begin
          if (byte_count >= CNT_MAX) begin
            // Oversized frame: drop sync and wait for the next delimiter.
            frame_open_next    = 1'b0;
            byte_count_next    = '0;
            is_data_frame_next = 1'b0;
            res.valid          = 1'b1;
            res.kind           = KIND_ABORT;
          end else if (byte_count == '0) begin
            is_data_frame_next = ((b & CMD_MASK) == CMD_DATA);
            byte_count_next    = CNT_ONE;
          end else begin
            byte_count_next = byte_count + CNT_ONE;
            if (is_data_frame) begin
              res.valid = 1'b1;
              res.kind  = KIND_DATA;
              res.data  = b;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      escape_pending <= 1'b0;
      frame_open     <= 1'b0;
      is_data_frame  <= 1'b0;
    end else begin
      byte_count     <= byte_count_next;
      escape_pending <= escape_pending_next;
      frame_open     <= frame_open_next;
      is_data_frame  <= is_data_frame_next;
    end
  end

  // The count saturates at the limit; the next stored byte aborts instead.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_MAX)
    else $error("byte count above frame limit");

  a_escape_in_frame: assert property (@(posedge clk) disable iff (rst)
    escape_pending |-> frame_open)
    else $error("escape pending outside a frame");

  a_data_has_cmd: assert property (@(posedge clk) disable iff (rst)
    is_data_frame |-> (frame_open && (byte_count != '0)))
    else $error("data frame flag without a command byte");

  a_abort_drops_sync: assert property (@(posedge clk) disable iff (rst)
    (step && res.valid && (res.kind == KIND_ABORT)) |=> !frame_open)
    else $error("sync kept after overflow abort");

endmodule

[design/kiss_frame_deframer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KISS frame deframer core
// Removes KISS framing and escapes from rx bytes, one per cycle unless res stalls.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries one raw serial byte per request. res carries at most one result
//   per byte: an unescaped payload byte (kind 0), a frame completion with the
//   payload length and port (kind 1), or an overflow abort (kind 2). cfg writes
//   the port number that completions report; it is always ready and should be
//   written only while the block is idle.
//   A result shows up on res from the output register: an accepted byte waits
//   in the input register, and the decode step loads its result into the
//   output register when that register can take it. Throughput is one byte
//   per cycle while res does not stall, set by the single-pass decode between
//   those two registers. When res stalls, the output register holds its result,
//   the input register holds the next byte, and rx.ready falls only once both
//   are full. While a result waits, no byte moves through the decode, even one
//   that yields none.
//   Synchronous reset empties both registers, drops frame sync (the block then
//   ignores bytes until a delimiter) and sets the port number to zero.
// ----------------------------------------------------------------------------
module kiss_frame_deframer_core
  import kissdf_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic   clk,
  input  logic   rst,
  kissdf_byte_if.sink   rx,
  kissdf_res_if.source  res,
  kissdf_cfg_if.sink    cfg
);

  // Port number register; the write channel never stalls.
  logic [PORT_W-1:0] port_number;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      port_number <= '0;
    end else if (cfg.valid) begin
      port_number <= cfg.port_number;
    end
  end

  // Input register. It moves on whenever the output register can take a
  // result, which is checked whether or not this byte yields one.
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              advance;
  logic              step;

  assign advance  = !res.valid || res.ready;
  assign rx.ready = !in_valid || advance;
  assign step     = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  // Framing state and the per-byte decision.
  result_t dec_res;

  kissdf_decode #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_decode (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .in_byte     (in_byte),
    .port_number (port_number),
    .res         (dec_res)
  );

  // Output register.
  logic              out_valid;
  kind_t             out_kind;
  logic [BYTE_W-1:0] out_byte;
  logic [LEN_W-1:0]  out_length;
  logic [PORT_W-1:0] out_port;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && dec_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && dec_res.valid) begin
      out_kind   <= dec_res.kind;
      out_byte   <= dec_res.data;
      out_length <= dec_res.length;
      out_port   <= dec_res.port;
    end
  end

  assign res.valid      = out_valid;
  assign res.out_kind   = out_kind;
  assign res.out_byte   = out_byte;
  assign res.out_length = out_length;
  assign res.out_port   = out_port;

endmodule
